>>> rtl/core/vehicle_mission_sequencer_top_macros.svh
// assertion macros shared by the mission sequencer rtl
`ifndef VEHICLE_MISSION_SEQUENCER_TOP_MACROS_SVH
`define VEHICLE_MISSION_SEQUENCER_TOP_MACROS_SVH

// cond must hold on the same edge as trig
`define VMS_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("vms assertion failed");

// cond must hold on the edge after trig
`define VMS_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("vms assertion failed");

`endif

>>> rtl/core/vms_pkg.sv
// types, codes and constants of the vehicle mission sequencer
package vms_pkg;

   // mission states
   localparam logic [2:0] ST_WAIT  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_BUZZ  = 3'd2;
   localparam logic [2:0] ST_DONE  = 3'd3;
   localparam logic [2:0] ST_FAULT = 3'd4;

   // fault kinds
   localparam logic [2:0] FK_NONE    = 3'd0;
   localparam logic [2:0] FK_CHASSIS = 3'd1;
   localparam logic [2:0] FK_SENSOR  = 3'd2;
   localparam logic [2:0] FK_BUSY    = 3'd3;
   localparam logic [2:0] FK_ROUTE   = 3'd4;

   // stop levels
   localparam logic [1:0] STOP_NONE   = 2'd0;
   localparam logic [1:0] STOP_BRAKE  = 2'd1;
   localparam logic [1:0] STOP_MOTION = 2'd2;
   localparam logic [1:0] STOP_ALL    = 2'd3;

   // start outcomes
   localparam logic [1:0] OUTCOME_OK     = 2'd0;
   localparam logic [1:0] OUTCOME_SENSOR = 2'd1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE_CONFIRM = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ARRIVAL_BUZZ    = 1'd1;

   // configuration reset values
   localparam logic [7:0]  RELEASE_CONFIRM_RESET = 8'd10;
   localparam logic [15:0] ARRIVAL_BUZZ_RESET    = 16'd1000;

   typedef struct packed {
      logic [7:0]  release_confirm_ticks;
      logic [15:0] arrival_buzz_ms;
   } vms_cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        start_key_down;
      logic        abort_key_down;
      logic        start_key_edge;
      logic        abort_key_edge;
      logic        route_info_ok;
      logic        route_at_goal;
      logic        route_failed;
      logic        follower_running;
      logic [7:0]  chassis_fault_code;
      logic [1:0]  start_outcome;
   } vms_item_type;

   typedef struct packed {
      logic [2:0]  cur_state;
      logic [2:0]  cur_fault;
      logic        keys_ready;
      logic [7:0]  release_count;
      logic [31:0] enter_time;
      logic [31:0] change_count;
      logic [1:0]  start_result;
      logic        buzz_level;
   } vms_state_type;

   typedef struct packed {
      logic [2:0]  mission_state;
      logic [2:0]  fault_kind;
      logic        armed;
      logic        buzzer_on;
      logic        start_request;
      logic [1:0]  stop_action;
      logic        clear_chassis_fault;
      logic [31:0] state_age_ms;
      logic [31:0] transitions;
      logic [1:0]  last_start_status;
   } vms_result_type;

endpackage

>>> rtl/core/vms_step.sv
// one tick of the mission sequencer: next state and result beat from one item
module vms_step
   import vms_pkg::*;
(
   input  vms_cfg_type    cfg,
   input  vms_state_type  cur,
   input  vms_item_type   item,
   output vms_state_type  nxt,
   output vms_result_type res
);

   logic        arrived;
   logic        failed;
   logic        start_edge;
   logic        abort_edge;
   logic        active;
   logic        start_req;
   logic        clear_req;
   logic [1:0]  stop_level;
   logic [31:0] elapsed;
   logic [7:0]  count_inc;
   logic [2:0]  fault_kind;

   always_comb begin
      nxt        = cur;
      start_req  = 1'b0;
      clear_req  = 1'b0;
      stop_level = STOP_NONE;
      count_inc  = cur.release_count;
      fault_kind = FK_NONE;
      elapsed    = item.now_ms - cur.enter_time;

      // invalid route info reads as not arrived, failed
      arrived = item.route_at_goal & item.route_info_ok;
      failed  = item.route_failed | ~item.route_info_ok;

      // edges count only once keys were armed before this tick
      start_edge = item.start_key_edge & cur.keys_ready;
      abort_edge = item.abort_key_edge & cur.keys_ready;

      // key arming: both released for the confirm count
      if (!cur.keys_ready) begin
         if (!item.start_key_down && !item.abort_key_down) begin
            if (cur.release_count < cfg.release_confirm_ticks) begin
               count_inc = cur.release_count + 8'd1;
            end
            if (count_inc >= cfg.release_confirm_ticks) begin
               nxt.keys_ready    = 1'b1;
               nxt.release_count = '0;
            end else begin
               nxt.release_count = count_inc;
            end
         end else begin
            nxt.release_count = '0;
         end
      end
      active = nxt.keys_ready;

      if (active && abort_edge) begin
         // abort: stop everything, back to waiting, disarm
         nxt.buzz_level    = 1'b0;
         stop_level        = STOP_ALL;
         clear_req         = (item.chassis_fault_code != 8'd0);
         nxt.cur_fault     = FK_NONE;
         nxt.start_result  = OUTCOME_OK;
         nxt.cur_state     = ST_WAIT;
         nxt.keys_ready    = 1'b0;
         nxt.release_count = '0;
      end else if (active) begin
         case (cur.cur_state)
            ST_WAIT, ST_DONE: begin
               if (cur.cur_state == ST_DONE) begin
                  stop_level = STOP_BRAKE;
               end
               if (start_edge) begin
                  // start attempt
                  nxt.buzz_level = 1'b0;
                  nxt.cur_fault  = FK_NONE;
                  if (item.chassis_fault_code != 8'd0) begin
                     fault_kind = FK_CHASSIS;
                  end else begin
                     start_req        = 1'b1;
                     nxt.start_result = item.start_outcome;
                     if (item.start_outcome == OUTCOME_OK) begin
                        nxt.cur_state = ST_RUN;
                     end else if (item.start_outcome == OUTCOME_SENSOR) begin
                        fault_kind = FK_SENSOR;
                     end else begin
                        fault_kind = FK_BUSY;
                     end
                  end
               end
            end
            ST_RUN: begin
               if (arrived) begin
                  stop_level     = STOP_MOTION;
                  nxt.buzz_level = 1'b1;
                  nxt.cur_state  = ST_BUZZ;
               end else if (item.chassis_fault_code != 8'd0) begin
                  fault_kind = FK_CHASSIS;
               end else if (failed || !item.follower_running) begin
                  fault_kind = FK_ROUTE;
               end
            end
            ST_BUZZ: begin
               stop_level = STOP_BRAKE;
               if (elapsed >= {16'd0, cfg.arrival_buzz_ms}) begin
                  nxt.buzz_level = 1'b0;
                  nxt.cur_state  = ST_DONE;
               end
            end
            ST_FAULT: begin
               nxt.buzz_level = 1'b0;
               stop_level     = STOP_BRAKE;
            end
            default: begin
               fault_kind = FK_ROUTE;
            end
         endcase

         // fault entry
         if (fault_kind != FK_NONE) begin
            nxt.cur_fault  = fault_kind;
            nxt.buzz_level = 1'b0;
            stop_level     = STOP_ALL;
            nxt.cur_state  = ST_FAULT;
         end
      end

      // state change bookkeeping
      if (nxt.cur_state != cur.cur_state) begin
         elapsed          = '0;
         nxt.enter_time   = item.now_ms;
         nxt.change_count = cur.change_count + 32'd1;
      end

      res.mission_state       = nxt.cur_state;
      res.fault_kind          = nxt.cur_fault;
      res.armed               = nxt.keys_ready;
      res.buzzer_on           = nxt.buzz_level;
      res.start_request       = start_req;
      res.stop_action         = stop_level;
      res.clear_chassis_fault = clear_req;
      res.state_age_ms        = elapsed;
      res.transitions         = nxt.change_count;
      res.last_start_status   = nxt.start_result;
   end

endmodule

>>> rtl/core/vehicle_mission_sequencer_top.sv
// top level of the vehicle mission sequencer: handshakes, state and result registers
//
//   channel | direction | handshake             | contents
//   req_    | in        | req_valid / req_ready | one control tick snapshot
//   rsp_    | out       | rsp_valid / rsp_ready | mission state and commands
//   csr_    | in        | csr_write_enable      | confirm ticks, buzzer time
//
// one beat per cycle sustained while rsp_ready is high; a beat passes from req to rsp through
// the input register, then the tick logic into the result register
// the tick logic updates mission state when a beat moves into the result register
// a stalled rsp holds the result; the input register still takes one more beat
// synchronous active-high reset clears mission state and both valid flags
`include "vehicle_mission_sequencer_top_macros.svh"

module vehicle_mission_sequencer_top
   import vms_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [31:0]                req_now_ms,
   input  logic                       req_start_key_down,
   input  logic                       req_abort_key_down,
   input  logic                       req_start_key_edge,
   input  logic                       req_abort_key_edge,
   input  logic                       req_route_info_ok,
   input  logic                       req_route_at_goal,
   input  logic                       req_route_failed,
   input  logic                       req_follower_running,
   input  logic [7:0]                 req_chassis_fault_code,
   input  logic [1:0]                 req_start_outcome,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [2:0]                 rsp_mission_state,
   output logic [2:0]                 rsp_fault_kind,
   output logic                       rsp_armed,
   output logic                       rsp_buzzer_on,
   output logic                       rsp_start_request,
   output logic [1:0]                 rsp_stop_action,
   output logic                       rsp_clear_chassis_fault,
   output logic [31:0]                rsp_state_age_ms,
   output logic [31:0]                rsp_transitions,
   output logic [1:0]                 rsp_last_start_status,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   vms_cfg_type    cfg_ff;
   vms_cfg_type    cfg_in;
   vms_state_type  state_ff;
   vms_state_type  state_in;
   vms_item_type   item_ff;
   vms_item_type   req_item;
   vms_result_type result_ff;
   vms_result_type result_in;
   logic           in_valid_ff;
   logic           out_valid_ff;
   logic           advance;

   // pack the request beat
   assign req_item = '{
      now_ms:             req_now_ms,
      start_key_down:     req_start_key_down,
      abort_key_down:     req_abort_key_down,
      start_key_edge:     req_start_key_edge,
      abort_key_edge:     req_abort_key_edge,
      route_info_ok:      req_route_info_ok,
      route_at_goal:      req_route_at_goal,
      route_failed:       req_route_failed,
      follower_running:   req_follower_running,
      chassis_fault_code: req_chassis_fault_code,
      start_outcome:      req_start_outcome
   };

   // handshake control
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;

   // configuration write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RELEASE_CONFIRM: cfg_in.release_confirm_ticks = csr_write_data[7:0];
            CSR_ARRIVAL_BUZZ:    cfg_in.arrival_buzz_ms       = csr_write_data[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.release_confirm_ticks <= RELEASE_CONFIRM_RESET;
         cfg_ff.arrival_buzz_ms       <= ARRIVAL_BUZZ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // tick logic
   vms_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_in),
      .res  (result_in)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   // mission state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_mission_state       = result_ff.mission_state;
   assign rsp_fault_kind          = result_ff.fault_kind;
   assign rsp_armed               = result_ff.armed;
   assign rsp_buzzer_on           = result_ff.buzzer_on;
   assign rsp_start_request       = result_ff.start_request;
   assign rsp_stop_action         = result_ff.stop_action;
   assign rsp_clear_chassis_fault = result_ff.clear_chassis_fault;
   assign rsp_state_age_ms        = result_ff.state_age_ms;
   assign rsp_transitions         = result_ff.transitions;
   assign rsp_last_start_status   = result_ff.last_start_status;

   // checks
   `VMS_ASSERT_SAME(a_armed_count_clear, clock, reset, state_ff.keys_ready, state_ff.release_count == 8'd0)
   `VMS_ASSERT_NEXT(a_change_counted, clock, reset, advance && (state_in.cur_state != state_ff.cur_state), state_ff.change_count == $past(state_ff.change_count) + 32'd1)
   `VMS_ASSERT_SAME(a_buzz_only_buzz, clock, reset, out_valid_ff && result_ff.buzzer_on, result_ff.mission_state == ST_BUZZ)
   `VMS_ASSERT_SAME(a_fault_only_fault, clock, reset, out_valid_ff && (result_ff.fault_kind != FK_NONE), result_ff.mission_state == ST_FAULT)
   `VMS_ASSERT_SAME(a_start_lands, clock, reset, out_valid_ff && result_ff.start_request, (result_ff.mission_state == ST_RUN) || (result_ff.mission_state == ST_FAULT))

endmodule

>>> test/tb_vehicle_mission_sequencer_top.sv
// testbench of the mission sequencer: directed and random control ticks checked against a local model
module tb_vehicle_mission_sequencer_top
   import vms_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD = 4;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [31:0]                req_now_ms;
   logic                       req_start_key_down;
   logic                       req_abort_key_down;
   logic                       req_start_key_edge;
   logic                       req_abort_key_edge;
   logic                       req_route_info_ok;
   logic                       req_route_at_goal;
   logic                       req_route_failed;
   logic                       req_follower_running;
   logic [7:0]                 req_chassis_fault_code;
   logic [1:0]                 req_start_outcome;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [2:0]                 rsp_mission_state;
   logic [2:0]                 rsp_fault_kind;
   logic                       rsp_armed;
   logic                       rsp_buzzer_on;
   logic                       rsp_start_request;
   logic [1:0]                 rsp_stop_action;
   logic                       rsp_clear_chassis_fault;
   logic [31:0]                rsp_state_age_ms;
   logic [31:0]                rsp_transitions;
   logic [1:0]                 rsp_last_start_status;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   // mission model: copy of the sequencer registers and its configuration
   logic [2:0]  mdl_state;
   logic [2:0]  mdl_fault;
   logic        mdl_armed;
   logic        mdl_buzz;
   logic [7:0]  mdl_release_cnt;
   logic [31:0] mdl_enter_ms;
   logic [31:0] mdl_changes;
   logic [1:0]  mdl_start_status;
   logic [7:0]  cfg_confirm_ticks;
   logic [15:0] cfg_buzz_ms;

   // per-tick scratch of the model
   logic [31:0] tk_now;
   logic [31:0] tk_elapsed;
   logic [1:0]  tk_stop;
   logic        tk_start_req;

   // expected reports, oldest first
   vms_result_type pending_reports[$];

   logic [31:0] sim_now_ms;
   bit          src_idle_on;
   bit          sink_idle_on;
   int unsigned sink_hold_cycles;
   int          err_count;

   vehicle_mission_sequencer_top dut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // keep the strongest stop command of the tick
   function void raise_stop(input logic [1:0] lvl);
      if (lvl > tk_stop) tk_stop = lvl;
   endfunction

   // a real change of state restarts the elapsed time and counts once
   function void enter_state(input logic [2:0] next_state);
      if (mdl_state != next_state) begin
         mdl_state = next_state;
         tk_elapsed = '0;
         mdl_enter_ms = tk_now;
         mdl_changes = mdl_changes + 32'd1;
      end
   endfunction

   function void enter_fault(input logic [2:0] kind);
      mdl_fault = kind;
      mdl_buzz = 1'b0;
      raise_stop(STOP_ALL);
      enter_state(ST_FAULT);
   endfunction

   // chassis fault blocks the start; otherwise the follower reply decides
   function void attempt_start(input logic [7:0] chassis, input logic [1:0] outcome);
      mdl_buzz = 1'b0;
      mdl_fault = FK_NONE;
      if (chassis != 8'd0) begin
         enter_fault(FK_CHASSIS);
      end else begin
         tk_start_req = 1'b1;
         mdl_start_status = outcome;
         if (outcome == OUTCOME_OK) enter_state(ST_RUN);
         else if (outcome == OUTCOME_SENSOR) enter_fault(FK_SENSOR);
         else enter_fault(FK_BUSY);
      end
   endfunction

   // one control tick of the mission model, returns the report it should give
   function automatic vms_result_type advance_mission(input vms_item_type it);
      vms_result_type want;
      logic arrived;
      logic failed;
      logic start_hit;
      logic abort_hit;
      logic active;
      logic clear_req;
      arrived = it.route_at_goal;
      failed = it.route_failed;
      start_hit = it.start_key_edge;
      abort_hit = it.abort_key_edge;
      active = 1'b1;
      clear_req = 1'b0;
      tk_now = it.now_ms;
      tk_elapsed = it.now_ms - mdl_enter_ms;
      tk_stop = STOP_NONE;
      tk_start_req = 1'b0;
      // invalid route info reads as an error, never as arrival
      if (!it.route_info_ok) begin
         arrived = 1'b0;
         failed = 1'b1;
      end
      // arming: both keys released for the confirm count, edges dropped meanwhile
      if (!mdl_armed) begin
         start_hit = 1'b0;
         abort_hit = 1'b0;
         if (!it.start_key_down && !it.abort_key_down) begin
            if (mdl_release_cnt < cfg_confirm_ticks) mdl_release_cnt = mdl_release_cnt + 8'd1;
            if (mdl_release_cnt >= cfg_confirm_ticks) begin
               mdl_armed = 1'b1;
               mdl_release_cnt = '0;
            end
         end else begin
            mdl_release_cnt = '0;
         end
         if (!mdl_armed) active = 1'b0;
      end
      // abort wins over everything and disarms
      if (active && abort_hit) begin
         mdl_buzz = 1'b0;
         raise_stop(STOP_ALL);
         if (it.chassis_fault_code != 8'd0) clear_req = 1'b1;
         mdl_fault = FK_NONE;
         mdl_start_status = OUTCOME_OK;
         enter_state(ST_WAIT);
         mdl_armed = 1'b0;
         mdl_release_cnt = '0;
      end else if (active) begin
         case (mdl_state)
            ST_WAIT: begin
               if (start_hit) attempt_start(it.chassis_fault_code, it.start_outcome);
            end
            ST_RUN: begin
               if (arrived) begin
                  raise_stop(STOP_MOTION);
                  mdl_buzz = 1'b1;
                  enter_state(ST_BUZZ);
               end else if (it.chassis_fault_code != 8'd0) begin
                  enter_fault(FK_CHASSIS);
               end else if (failed || !it.follower_running) begin
                  enter_fault(FK_ROUTE);
               end
            end
            ST_BUZZ: begin
               raise_stop(STOP_BRAKE);
               if (tk_elapsed >= {16'd0, cfg_buzz_ms}) begin
                  mdl_buzz = 1'b0;
                  enter_state(ST_DONE);
               end
            end
            ST_DONE: begin
               raise_stop(STOP_BRAKE);
               if (start_hit) attempt_start(it.chassis_fault_code, it.start_outcome);
            end
            ST_FAULT: begin
               mdl_buzz = 1'b0;
               raise_stop(STOP_BRAKE);
            end
            default: enter_fault(FK_ROUTE);
         endcase
      end
      want.mission_state = mdl_state;
      want.fault_kind = mdl_fault;
      want.armed = mdl_armed;
      want.buzzer_on = mdl_buzz;
      want.start_request = tk_start_req;
      want.stop_action = tk_stop;
      want.clear_chassis_fault = clear_req;
      want.state_age_ms = tk_elapsed;
      want.transitions = mdl_changes;
      want.last_start_status = mdl_start_status;
      return want;
   endfunction

   // quiet tick: keys released, route fine, follower running, time moved on
   function automatic vms_item_type plain_tick(input logic [31:0] step_ms);
      vms_item_type it;
      sim_now_ms = sim_now_ms + step_ms;
      it = '0;
      it.now_ms = sim_now_ms;
      it.route_info_ok = 1'b1;
      it.follower_running = 1'b1;
      it.start_outcome = OUTCOME_OK;
      return it;
   endfunction

   // random tick shaped by the model state so that missions run to the end
   function automatic vms_item_type next_mission_tick();
      vms_item_type it;
      logic [63:0] noise_bits;
      int unsigned step_ms;
      int unsigned roll;
      if (mdl_state == ST_BUZZ) step_ms = $urandom_range(0, cfg_buzz_ms / 3 + 1);
      else step_ms = $urandom_range(0, 40);
      if ($urandom_range(0, 199) == 0) step_ms = $urandom;
      it = plain_tick(step_ms);
      roll = $urandom_range(0, 99);
      if (!mdl_armed) begin
         // keys mostly released so arming completes; edges are dropped here
         if ($urandom_range(0, 4 * cfg_confirm_ticks + 8) == 0) begin
            it.start_key_down = 1'($urandom);
            it.abort_key_down = 1'($urandom);
         end
         it.start_key_edge = 1'($urandom);
         it.abort_key_edge = 1'($urandom);
         it.chassis_fault_code = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
         it.start_outcome = 2'($urandom);
      end else if (roll < 6) begin
         // noise: every field but now_ms random
         noise_bits = {$urandom, $urandom};
         it = noise_bits[$bits(vms_item_type)-1:0];
         it.now_ms = sim_now_ms;
      end else begin
         case (mdl_state)
            ST_WAIT, ST_DONE: begin
               it.start_key_edge = ($urandom_range(0, 1) == 0);
               it.start_key_down = it.start_key_edge | ($urandom_range(0, 3) == 0);
               if ($urandom_range(0, 9) == 0) it.chassis_fault_code = 8'($urandom_range(1, 255));
               if ($urandom_range(0, 9) >= 7) it.start_outcome = 2'($urandom_range(1, 3));
            end
            ST_RUN: begin
               if (roll < 16) begin
                  it.route_at_goal = 1'b1;
                  if ($urandom_range(0, 3) == 0) it.chassis_fault_code = 8'($urandom);
                  if ($urandom_range(0, 3) == 0) it.route_failed = 1'b1;
               end else if (roll < 20) begin
                  it.chassis_fault_code = 8'($urandom_range(1, 255));
               end else if (roll < 23) begin
                  it.route_failed = 1'b1;
               end else if (roll < 26) begin
                  it.route_info_ok = 1'b0;
                  it.route_at_goal = 1'($urandom);
               end else if (roll < 29) begin
                  it.follower_running = 1'b0;
               end
            end
            ST_FAULT: begin
               if ($urandom_range(0, 3) == 0) it.abort_key_edge = 1'b1;
            end
            default: ;
         endcase
         if ($urandom_range(0, 49) == 0) it.abort_key_edge = 1'b1;
         if (it.abort_key_edge) begin
            it.abort_key_down = 1'b1;
            if ($urandom_range(0, 1) == 0) it.chassis_fault_code = 8'($urandom);
         end
      end
      return it;
   endfunction

   // one beat on the request channel, predicted when accepted
   task automatic send_tick(input vms_item_type it);
      int unsigned gap;
      if (src_idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_now_ms <= it.now_ms;
      req_start_key_down <= it.start_key_down;
      req_abort_key_down <= it.abort_key_down;
      req_start_key_edge <= it.start_key_edge;
      req_abort_key_edge <= it.abort_key_edge;
      req_route_info_ok <= it.route_info_ok;
      req_route_at_goal <= it.route_at_goal;
      req_route_failed <= it.route_failed;
      req_follower_running <= it.follower_running;
      req_chassis_fault_code <= it.chassis_fault_code;
      req_start_outcome <= it.start_outcome;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_reports.push_back(advance_mission(it));
   endtask

   task automatic run_random_ticks(input int unsigned count);
      repeat (count) send_tick(next_mission_tick());
   endtask

   // stop sending and wait for every report, then let the pipeline go quiet
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_RELEASE_CONFIRM) cfg_confirm_ticks = data[7:0];
      else cfg_buzz_ms = data;
   endtask

   task automatic config_phase(input logic [7:0] confirm, input logic [15:0] buzz_ms,
                               input int unsigned count);
      settle_idle();
      write_csr(CSR_RELEASE_CONFIRM, {8'd0, confirm});
      write_csr(CSR_ARRIVAL_BUZZ, buzz_ms);
      run_random_ticks(count);
   endtask

   // arming with the reset confirm count: held keys, count restart, dropped edges
   task automatic test_arming_directed();
      vms_item_type it;
      sim_now_ms = '0;
      it = plain_tick(0);
      it.start_key_down = 1'b1;
      it.abort_key_down = 1'b1;
      it.start_key_edge = 1'b1;
      it.abort_key_edge = 1'b1;
      send_tick(it);
      send_tick(plain_tick(1));
      it = plain_tick(1);
      it.abort_key_down = 1'b1;
      send_tick(it);
      for (int i = 0; i < 9; i++) begin
         it = plain_tick(1);
         it.abort_key_edge = (i == 4);
         send_tick(it);
      end
      // tenth released tick arms, its edges are still dropped
      it = plain_tick(1);
      it.start_key_edge = 1'b1;
      it.abort_key_edge = 1'b1;
      send_tick(it);
   endtask

   // full mission across the time wrap, start refusals, abort with chassis clear
   task automatic test_mission_directed();
      vms_item_type it;
      settle_idle();
      write_csr(CSR_RELEASE_CONFIRM, 16'd1);
      sim_now_ms = 32'hFFFF_FC00;
      it = plain_tick(0);
      it.start_key_edge = 1'b1;
      it.start_key_down = 1'b1;
      send_tick(it);
      sim_now_ms = 32'hFFFF_FFFF;
      send_tick(plain_tick(0));
      sim_now_ms = 32'h0000_0010;
      it = plain_tick(0);
      it.route_at_goal = 1'b1;
      send_tick(it);
      send_tick(plain_tick(999));
      send_tick(plain_tick(1));
      // start from complete while the chassis reports a fault
      it = plain_tick(3);
      it.start_key_edge = 1'b1;
      it.chassis_fault_code = 8'hFF;
      send_tick(it);
      it = plain_tick(3);
      it.start_key_edge = 1'b1;
      send_tick(it);
      it = plain_tick(3);
      it.abort_key_edge = 1'b1;
      it.abort_key_down = 1'b1;
      it.chassis_fault_code = 8'hFF;
      send_tick(it);
      it = plain_tick(3);
      it.start_key_edge = 1'b1;
      send_tick(it);
      // odd follower reply counts as busy and is kept as given
      it = plain_tick(3);
      it.start_key_edge = 1'b1;
      it.start_outcome = 2'd3;
      send_tick(it);
      it = plain_tick(3);
      it.abort_key_edge = 1'b1;
      it.abort_key_down = 1'b1;
      send_tick(it);
      send_tick(plain_tick(3));
      it = plain_tick(3);
      it.start_key_edge = 1'b1;
      send_tick(it);
      // arrival reported with invalid route info is a route fault
      it = plain_tick(3);
      it.route_info_ok = 1'b0;
      it.route_at_goal = 1'b1;
      send_tick(it);
   endtask

   // register extremes: zero and full confirm count, zero and full buzzer time
   task automatic test_config_sweep();
      config_phase(8'd0, 16'd1, 150);
      config_phase(8'd1, 16'd0, 200);
      config_phase(8'd255, 16'hFFFF, 350);
      config_phase(8'd2, 16'd300, 150);
   endtask

   task automatic test_random_missions();
      repeat (4) begin
         config_phase(8'($urandom_range(1, 6)), 16'($urandom_range(0, 1500)), 100);
      end
   endtask

   // long receiver hold fills the block while the sender keeps offering
   task automatic test_backpressure();
      src_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      sink_hold_cycles = 40;
      run_random_ticks(30);
      settle_idle();
      run_random_ticks(30);
      src_idle_on = 1'b1;
      sink_idle_on = 1'b1;
   endtask

   // closing stretch at full rate on both sides
   task automatic test_streaming_tail();
      src_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      run_random_ticks(120);
   endtask

   function void check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endfunction

   // compare each report beat with the oldest expectation
   always @(posedge clock) begin : report_check
      vms_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("report beat with nothing expected");
            err_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("mission_state", 32'(want.mission_state), 32'(rsp_mission_state));
            check_field("fault_kind", 32'(want.fault_kind), 32'(rsp_fault_kind));
            check_field("armed", 32'(want.armed), 32'(rsp_armed));
            check_field("buzzer_on", 32'(want.buzzer_on), 32'(rsp_buzzer_on));
            check_field("start_request", 32'(want.start_request), 32'(rsp_start_request));
            check_field("stop_action", 32'(want.stop_action), 32'(rsp_stop_action));
            check_field("clear_chassis_fault", 32'(want.clear_chassis_fault),
                        32'(rsp_clear_chassis_fault));
            check_field("state_age_ms", want.state_age_ms, rsp_state_age_ms);
            check_field("transitions", want.transitions, rsp_transitions);
            check_field("last_start_status", 32'(want.last_start_status),
                        32'(rsp_last_start_status));
         end
      end
   end

   // report receiver: random stall bursts, or one long hold on request
   initial begin : report_sink
      int unsigned stall_len;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (sink_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (sink_hold_cycles) @(negedge clock);
            sink_hold_cycles = 0;
            rsp_ready <= 1'b1;
         end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
            stall_len = $urandom_range(1, 12);
            rsp_ready <= 1'b0;
            repeat (stall_len) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // run limit
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int unsigned flush_wait;
      reset = 1'b1;
      req_valid = 1'b0;
      req_now_ms = '0;
      req_start_key_down = 1'b0;
      req_abort_key_down = 1'b0;
      req_start_key_edge = 1'b0;
      req_abort_key_edge = 1'b0;
      req_route_info_ok = 1'b0;
      req_route_at_goal = 1'b0;
      req_route_failed = 1'b0;
      req_follower_running = 1'b0;
      req_chassis_fault_code = '0;
      req_start_outcome = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      src_idle_on = 1'b1;
      sink_idle_on = 1'b1;
      sink_hold_cycles = 0;
      err_count = 0;
      sim_now_ms = '0;
      mdl_state = ST_WAIT;
      mdl_fault = FK_NONE;
      mdl_armed = 1'b0;
      mdl_buzz = 1'b0;
      mdl_release_cnt = '0;
      mdl_enter_ms = '0;
      mdl_changes = '0;
      mdl_start_status = OUTCOME_OK;
      cfg_confirm_ticks = RELEASE_CONFIRM_RESET;
      cfg_buzz_ms = ARRIVAL_BUZZ_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_arming_directed();
      test_mission_directed();
      test_config_sweep();
      test_random_missions();
      test_backpressure();
      test_streaming_tail();

      // drain the last reports, bounded
      @(negedge clock);
      req_valid <= 1'b0;
      flush_wait = 0;
      while (pending_reports.size() != 0 && flush_wait < 2000) begin
         @(posedge clock);
         flush_wait++;
      end
      repeat (4) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $error("%0d reports never arrived", pending_reports.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
